FILE: src/first_fit_block_allocator_defines.svh
// Assertion macros shared by the checker of the block allocator.
// Depends on nothing; included by the checker file only.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFBA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
// Used by the table memory, the sequencer and the top level.
`timescale 1ns / 1ps
package ffba_pkg;

    localparam int HEADER_BYTES  = 24;
    localparam int GRANULE_BYTES = 32;
    localparam logic [16:0] POOL_MAX = 17'd65536;
    localparam logic [16:0] POOL_MIN = 17'(HEADER_BYTES + GRANULE_BYTES);
    localparam logic [16:0] SPLIT_MIN = 17'(HEADER_BYTES + GRANULE_BYTES);

    localparam logic FUNC_ALLOC = 1'b0;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_NOFIT = 2'd1,
        STATUS_BAD   = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0] start;
        logic [15:0] len;
        logic        free;
    } entry_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_A_RD,
        ST_A_CHK,
        ST_S_RD,
        ST_S_WR,
        ST_S_NEW,
        ST_S_OLD,
        ST_W_TAKE,
        ST_F_RD,
        ST_F_CHK,
        ST_F_MARK,
        ST_M_RD0,
        ST_M_LD,
        ST_M_NX,
        ST_M_CK,
        ST_D_RD,
        ST_D_WR
    } state_t;

endpackage

FILE: src/ffba_table.sv
// Block table memory with one write port and one registered read port.
// Entry 0 reads as the initial free block until it is first written and again after each reinit.
// Depends on ffba_pkg.
`timescale 1ns / 1ps
module ffba_table
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          reinit,
    input  logic [15:0]                   init_len,
    input  logic [$clog2(MAX_BLOCKS)-1:0] rd_addr,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_BLOCKS)-1:0] wr_addr,
    input  entry_t                        wr_data,
    output entry_t                        rd_data
);

    localparam int IW = $clog2(MAX_BLOCKS);

    entry_t mem [MAX_BLOCKS];
    entry_t mem_q_reg;
    logic   init_valid_reg;
    logic   init_valid_next;
    logic   use_init_reg;
    entry_t init_entry;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg <= mem[rd_addr];
    end

    always_comb
    begin
        init_valid_next = init_valid_reg;
        if (wr_en && wr_addr == IW'(0))
        begin
            init_valid_next = 1'b0;
        end
        if (reinit)
        begin
            init_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_valid_reg <= 1'b1;
            use_init_reg   <= 1'b0;
        end
        else
        begin
            init_valid_reg <= init_valid_next;
            use_init_reg   <= init_valid_reg && rd_addr == IW'(0);
        end
    end

    assign init_entry = '{start: 16'd0, len: init_len, free: 1'b1};
    assign rd_data    = use_init_reg ? init_entry : mem_q_reg;

endmodule

FILE: src/ffba_seq.sv
// Sequencer of the allocator: scans, splits, marks and merges table entries
// one memory access per cycle.
// Depends on ffba_pkg.
`timescale 1ns / 1ps
module ffba_seq
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          func,
    input  logic [15:0]                   req_size,
    input  logic [15:0]                   block_addr,
    input  logic                          reinit,
    output logic                          busy,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [15:0]                   payload_addr,
    output logic [$clog2(MAX_BLOCKS)-1:0] rd_addr,
    output logic                          wr_en,
    output logic [$clog2(MAX_BLOCKS)-1:0] wr_addr,
    output entry_t                        wr_data,
    input  entry_t                        rd_data
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    state_t         state_reg, state_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [CW-1:0]  k_reg, k_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [16:0]    need_reg, need_next;
    entry_t         cur_reg, cur_next;
    logic           func_reg, func_next;
    logic [15:0]    addr_reg, addr_next;
    logic           done_reg, done_next;
    logic [1:0]     status_reg, status_next;
    logic [15:0]    paddr_reg, paddr_next;

    logic [CW-1:0]  i_inc;
    logic [CW-1:0]  k_inc;
    logic [CW-1:0]  k_dec;
    logic [16:0]    rounded;
    logic [16:0]    spare;
    logic [15:0]    merged_len;
    logic [15:0]    cur_payload;

    assign i_inc       = i_reg + CW'(1);
    assign k_inc       = k_reg + CW'(1);
    assign k_dec       = k_reg - CW'(1);
    assign rounded     = {1'b0, req_size} + 17'(GRANULE_BYTES - 1);
    assign spare       = {1'b0, rd_data.len} - need_reg;
    assign merged_len  = cur_reg.len + rd_data.len + 16'(HEADER_BYTES);
    assign cur_payload = cur_reg.start + 16'(HEADER_BYTES);

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        count_next  = count_reg;
        need_next   = need_reg;
        cur_next    = cur_reg;
        func_next   = func_reg;
        addr_next   = addr_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        paddr_next  = paddr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next  = func;
                    addr_next  = block_addr;
                    need_next  = 17'((rounded / GRANULE_BYTES) * GRANULE_BYTES);
                    i_next     = '0;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (func_reg == FUNC_ALLOC)
                begin
                    if (need_reg == 17'd0)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_BAD;
                        paddr_next  = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_A_RD;
                    end
                end
                else
                begin
                    state_next = ST_F_RD;
                end
            end
            ST_A_RD:
            begin
                if (i_reg >= count_reg)
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_NOFIT;
                    paddr_next  = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_A_CHK;
                end
            end
            ST_A_CHK:
            begin
                if (rd_data.free && {1'b0, rd_data.len} >= need_reg)
                begin
                    cur_next = rd_data;
                    if (spare >= SPLIT_MIN && count_reg < CW'(MAX_BLOCKS))
                    begin
                        k_next     = count_reg;
                        state_next = ST_S_RD;
                    end
                    else
                    begin
                        state_next = ST_W_TAKE;
                    end
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = ST_A_RD;
                end
            end
            ST_S_RD:
            begin
                if (k_reg > i_inc)
                begin
                    state_next = ST_S_WR;
                end
                else
                begin
                    state_next = ST_S_NEW;
                end
            end
            ST_S_WR:
            begin
                k_next     = k_dec;
                state_next = ST_S_RD;
            end
            ST_S_NEW:
            begin
                state_next = ST_S_OLD;
            end
            ST_S_OLD:
            begin
                count_next  = count_reg + CW'(1);
                done_next   = 1'b1;
                status_next = STATUS_DONE;
                paddr_next  = cur_payload;
                state_next  = ST_IDLE;
            end
            ST_W_TAKE:
            begin
                done_next   = 1'b1;
                status_next = STATUS_DONE;
                paddr_next  = cur_payload;
                state_next  = ST_IDLE;
            end
            ST_F_RD:
            begin
                if (i_reg >= count_reg)
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_BAD;
                    paddr_next  = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_F_CHK;
                end
            end
            ST_F_CHK:
            begin
                if ({1'b0, rd_data.start} + 17'(HEADER_BYTES) == {1'b0, addr_reg})
                begin
                    if (rd_data.free)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_BAD;
                        paddr_next  = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        cur_next   = rd_data;
                        state_next = ST_F_MARK;
                    end
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = ST_F_RD;
                end
            end
            ST_F_MARK:
            begin
                i_next     = '0;
                state_next = ST_M_RD0;
            end
            ST_M_RD0:
            begin
                state_next = ST_M_LD;
            end
            ST_M_LD:
            begin
                cur_next   = rd_data;
                state_next = ST_M_NX;
            end
            ST_M_NX:
            begin
                if (i_inc >= count_reg)
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_DONE;
                    paddr_next  = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_M_CK;
                end
            end
            ST_M_CK:
            begin
                if (cur_reg.free && rd_data.free)
                begin
                    cur_next.len = merged_len;
                    k_next       = i_inc;
                    state_next   = ST_D_RD;
                end
                else
                begin
                    cur_next   = rd_data;
                    i_next     = i_inc;
                    state_next = ST_M_NX;
                end
            end
            ST_D_RD:
            begin
                if (k_inc < count_reg)
                begin
                    state_next = ST_D_WR;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_M_NX;
                end
            end
            ST_D_WR:
            begin
                k_next     = k_inc;
                state_next = ST_D_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (reinit)
        begin
            count_next = CW'(1);
        end
    end

    always_comb
    begin
        rd_addr = i_reg[IW-1:0];
        wr_en   = 1'b0;
        wr_addr = i_reg[IW-1:0];
        wr_data = rd_data;
        case (state_reg)
            ST_S_RD:
            begin
                rd_addr = k_dec[IW-1:0];
            end
            ST_S_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = k_reg[IW-1:0];
            end
            ST_S_NEW:
            begin
                wr_en   = 1'b1;
                wr_addr = i_inc[IW-1:0];
                wr_data = '{start: cur_payload + need_reg[15:0],
                            len:   cur_reg.len - need_reg[15:0] - 16'(HEADER_BYTES),
                            free:  1'b1};
            end
            ST_S_OLD:
            begin
                wr_en   = 1'b1;
                wr_data = '{start: cur_reg.start, len: need_reg[15:0], free: 1'b0};
            end
            ST_W_TAKE:
            begin
                wr_en   = 1'b1;
                wr_data = '{start: cur_reg.start, len: cur_reg.len, free: 1'b0};
            end
            ST_F_MARK:
            begin
                wr_en   = 1'b1;
                wr_data = '{start: cur_reg.start, len: cur_reg.len, free: 1'b1};
            end
            ST_M_RD0:
            begin
                rd_addr = '0;
            end
            ST_M_NX:
            begin
                rd_addr = i_inc[IW-1:0];
            end
            ST_M_CK:
            begin
                if (cur_reg.free && rd_data.free)
                begin
                    wr_en   = 1'b1;
                    wr_data = '{start: cur_reg.start, len: merged_len, free: 1'b1};
                end
            end
            ST_D_RD:
            begin
                rd_addr = k_inc[IW-1:0];
            end
            ST_D_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = k_reg[IW-1:0];
            end
            default:
            begin
                rd_addr = i_reg[IW-1:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= CW'(1);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        k_reg      <= k_next;
        need_reg   <= need_next;
        cur_reg    <= cur_next;
        func_reg   <= func_next;
        addr_reg   <= addr_next;
        status_reg <= status_next;
        paddr_reg  <= paddr_next;
    end

    assign busy         = state_reg != ST_IDLE;
    assign done         = done_reg;
    assign status       = status_reg;
    assign payload_addr = paddr_reg;

endmodule

FILE: src/first_fit_block_allocator.sv
// First-fit block allocator over a byte pool with split and coalesce.
// Order of work: an allocate scans table entries and, for a split, moves the later entries
// up by one; a free scans entries, marks the match free, then walks the table merging
// adjacent free blocks and moving later entries down. One request at a time; done pulses
// one cycle as busy falls, and the receiver cannot stall.
// Reset holds one free block covering the 65536-byte pool; no clearing pass is run.
`timescale 1ns / 1ps
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [15:0] req_size,
    input  logic [15:0] block_addr,
    output logic        done,
    output logic [1:0]  status,
    output logic [15:0] payload_addr,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] pool_bytes
);

    localparam int IW = $clog2(MAX_BLOCKS);

    logic [16:0]   pool_reg, pool_next;
    logic          cfg_we;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_data;
    entry_t        rd_data;
    logic [16:0]   init_len;

    assign cfg_ready = !busy;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        pool_next = pool_reg;
        if (cfg_we)
        begin
            if (pool_bytes < POOL_MIN)
            begin
                pool_next = POOL_MIN;
            end
            else if (pool_bytes > POOL_MAX)
            begin
                pool_next = POOL_MAX;
            end
            else
            begin
                pool_next = pool_bytes;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg <= POOL_MAX;
        end
        else
        begin
            pool_reg <= pool_next;
        end
    end

    assign init_len = pool_reg - 17'(HEADER_BYTES);

    ffba_table #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .reinit   (cfg_we),
        .init_len (init_len[15:0]),
        .rd_addr  (rd_addr),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_data  (rd_data)
    );

    ffba_seq #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .func         (func),
        .req_size     (req_size),
        .block_addr   (block_addr),
        .reinit       (cfg_we),
        .busy         (busy),
        .done         (done),
        .status       (status),
        .payload_addr (payload_addr),
        .rd_addr      (rd_addr),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_data      (rd_data)
    );

endmodule

FILE: src/ffba_checker.sv
// Port-level checker of the block allocator and its bind to the top level.
// Depends on ffba_pkg and first_fit_block_allocator_defines.svh.
`timescale 1ns / 1ps
`include "first_fit_block_allocator_defines.svh"
module ffba_checker
    import ffba_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic [15:0] payload_addr
);

    `FFBA_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "accepted beat did not raise busy")
    `FFBA_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy, "result strobe while busy")
    `FFBA_ASSERT_SAME(a_fell_done, clk, rst_n, $fell(busy), done, "busy fell without a result")
    `FFBA_ASSERT_SAME(a_err_zero, clk, rst_n, done && status != STATUS_DONE, payload_addr == 16'd0, "nonzero offset on failed request")

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .payload_addr (payload_addr)
);
